### rtl/wsnl_pkg.sv
`default_nettype none
package wsnl_pkg;

	localparam int unsigned ENTRIES_DEF  = 32;
	localparam int unsigned DIAL_LEN_DEF = 32;

	localparam logic [7:0] CH_NUL  = 8'h00;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		CMD_WR_REG    = 2'd0,
		CMD_SET_VALID = 2'd1,
		CMD_WR_RX     = 2'd2,
		CMD_LOOKUP    = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t       command;
		logic [4:0] entry_index;
		logic [4:0] char_position;
		logic [7:0] char_value;
		logic       valid_value;
		logic [5:0] received_length;
	} req_t;

	typedef struct packed {
		logic       found;
		logic [4:0] match_index;
	} rsp_t;

	// sequencer -> top: result of one transaction
	typedef struct packed {
		logic       done;
		logic       found;
		logic [4:0] match_index;
	} seq_res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLAG_WR,
		ST_RX_CHK,
		ST_ENT_START,
		ST_ENT_END,
		ST_ENT_CMP
	} state_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_kept(input logic [7:0] c);
		return is_digit(c) || (c == CH_STAR);
	endfunction

endpackage
`default_nettype wire

### rtl/wsnl_stream_if.sv
`default_nettype none
interface wsnl_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/wsnl_ram.sv
`default_nettype none
module wsnl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_a,
	output logic [WIDTH-1:0] rdata_b
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rd_a_q;
	assign rdata_b = rd_b_q;
endmodule
`default_nettype wire

### rtl/wsnl_seq.sv
`default_nettype none
module wsnl_seq #(
	parameter int unsigned ENTRIES  = wsnl_pkg::ENTRIES_DEF,
	parameter int unsigned DIAL_LEN = wsnl_pkg::DIAL_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  wsnl_pkg::req_t     req,
	output logic               busy,
	output wsnl_pkg::seq_res_t res
);
	import wsnl_pkg::*;

	localparam int unsigned EW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned RW  = $clog2(ENTRIES + 1);   // rows: entries + received row
	localparam int unsigned PW  = $clog2(DIAL_LEN);
	localparam int unsigned CW  = $clog2(DIAL_LEN + 1);  // counts 0..DIAL_LEN
	localparam int unsigned CAW = RW + PW;
	localparam logic [RW-1:0] RX_ROW = RW'(ENTRIES);
	localparam logic [EW-1:0] LAST_ENT = EW'(ENTRIES - 1);

	state_t              state_q, state_d;
	logic [EW-1:0]       ent_q, ent_d;
	logic [PW-1:0]       pos_q, pos_d;
	logic                zero_q, zero_d;
	logic [CW-1:0]       len_q, len_d;
	logic [CW-1:0]       k_q, k_d;
	logic [CW-1:0]       rx_cnt_q, rx_cnt_d;
	logic [CW-1:0]       dcnt_q, dcnt_d;
	logic [CW-1:0]       rcnt_q, rcnt_d;
	logic                seen_q, seen_d;
	logic [ENTRIES-1:0]  valid_q;

	logic                c_we;
	logic [CAW-1:0]      c_waddr, c_raddr_a, c_raddr_b;
	logic [7:0]          c_wdata, c_rdata_a, c_rdata_b;
	logic                f_we;
	logic [EW-1:0]       f_waddr, f_raddr;
	logic [DIAL_LEN-1:0] f_wdata, f_rdata;

	logic                ei_ok, cp_ok;
	logic [CW-1:0]       len_sat;
	logic [CW-1:0]       end_cnt;
	logic                kept, fail, consume, seen_n;
	logic [CW-1:0]       dnext, rnext;

	// character store: one row per entry, row ENTRIES holds the received number
	wsnl_ram #(.WIDTH(8), .DEPTH(2 ** CAW)) u_chars (
		.clk     (clk),
		.we      (c_we),
		.waddr   (c_waddr),
		.wdata   (c_wdata),
		.raddr_a (c_raddr_a),
		.raddr_b (c_raddr_b),
		.rdata_a (c_rdata_a),
		.rdata_b (c_rdata_b)
	);

	// per-entry mask of positions that hold a zero character
	wsnl_ram #(.WIDTH(DIAL_LEN), .DEPTH(2 ** EW)) u_zflags (
		.clk     (clk),
		.we      (f_we),
		.waddr   (f_waddr),
		.wdata   (f_wdata),
		.raddr_a (f_raddr),
		.raddr_b (f_raddr),
		.rdata_a (f_rdata),
		.rdata_b ()
	);

	assign ei_ok   = 9'(req.entry_index) < 9'(ENTRIES);
	assign cp_ok   = 7'(req.char_position) < 7'(DIAL_LEN);
	assign len_sat = (7'(req.received_length) > 7'(DIAL_LEN)) ? CW'(DIAL_LEN)
	                                                          : CW'(req.received_length);

	// entry ends before the first zero at position 1 or above
	always_comb begin
		end_cnt = CW'(DIAL_LEN);
		for (int p = DIAL_LEN - 1; p >= 1; p--) begin
			if (f_rdata[p]) begin
				end_cnt = CW'(p);
			end
		end
	end

	// one step of the backward compare
	assign kept    = is_kept(c_rdata_a);
	assign fail    = (rcnt_q == '0) || (kept && (c_rdata_a != CH_STAR) && (c_rdata_a != c_rdata_b));
	assign consume = kept && !fail;
	assign seen_n  = seen_q || consume;
	assign dnext   = dcnt_q - 1'b1;
	assign rnext   = consume ? rcnt_q - 1'b1 : rcnt_q;

	always_comb begin
		state_d   = state_q;
		ent_d     = ent_q;
		pos_d     = pos_q;
		zero_d    = zero_q;
		len_d     = len_q;
		k_d       = k_q;
		rx_cnt_d  = rx_cnt_q;
		dcnt_d    = dcnt_q;
		rcnt_d    = rcnt_q;
		seen_d    = seen_q;
		c_we      = 1'b0;
		c_waddr   = {RW'(req.entry_index), PW'(req.char_position)};
		c_wdata   = req.char_value;
		c_raddr_a = '0;
		c_raddr_b = '0;
		f_we      = 1'b0;
		f_waddr   = ent_q;
		f_wdata   = f_rdata;
		f_raddr   = ent_q;
		res       = '0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (req.command)
						CMD_WR_REG: begin
							res.done = 1'b1;
							if (ei_ok && cp_ok) begin
								c_we    = 1'b1;
								f_raddr = EW'(req.entry_index);
								ent_d   = EW'(req.entry_index);
								pos_d   = PW'(req.char_position);
								zero_d  = (req.char_value == CH_NUL);
								state_d = ST_FLAG_WR;
							end
						end
						CMD_SET_VALID: begin
							res.done = 1'b1;
						end
						CMD_WR_RX: begin
							res.done = 1'b1;
							if (cp_ok) begin
								c_we    = 1'b1;
								c_waddr = {RX_ROW, PW'(req.char_position)};
							end
						end
						CMD_LOOKUP: begin
							len_d     = len_sat;
							k_d       = '0;
							c_raddr_b = {RX_ROW, PW'(0)};
							state_d   = ST_RX_CHK;
						end
						default: begin
							res.done = 1'b1;
						end
					endcase
				end
			end

			ST_FLAG_WR: begin
				f_we           = 1'b1;
				f_wdata[pos_q] = zero_q;
				state_d        = ST_IDLE;
			end

			// count the leading digits of the received number
			ST_RX_CHK: begin
				if ((k_q < len_q) && is_digit(c_rdata_b)) begin
					k_d       = k_q + 1'b1;
					c_raddr_b = {RX_ROW, PW'(k_q + 1'b1)};
				end else begin
					rx_cnt_d = k_q;
					ent_d    = '0;
					if (k_q == '0) begin
						res.done = 1'b1;
						state_d  = ST_IDLE;
					end else begin
						state_d  = ST_ENT_START;
					end
				end
			end

			ST_ENT_START: begin
				if (valid_q[ent_q]) begin
					state_d = ST_ENT_END;
				end else if (ent_q == LAST_ENT) begin
					res.done = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					ent_d = ent_q + 1'b1;
				end
			end

			ST_ENT_END: begin
				dcnt_d    = end_cnt;
				rcnt_d    = rx_cnt_q;
				seen_d    = 1'b0;
				c_raddr_a = {RW'(ent_q), PW'(end_cnt - 1'b1)};
				c_raddr_b = {RX_ROW, PW'(rx_cnt_q - 1'b1)};
				state_d   = ST_ENT_CMP;
			end

			ST_ENT_CMP: begin
				if (!fail && (dnext != '0)) begin
					dcnt_d    = dnext;
					rcnt_d    = rnext;
					seen_d    = seen_n;
					c_raddr_a = {RW'(ent_q), PW'(dnext - 1'b1)};
					c_raddr_b = {RX_ROW, PW'(rnext - 1'b1)};
				end else if (!fail && seen_n) begin
					res.done        = 1'b1;
					res.found       = 1'b1;
					res.match_index = 5'(ent_q);
					state_d         = ST_IDLE;
				end else if (ent_q == LAST_ENT) begin
					res.done = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					ent_d   = ent_q + 1'b1;
					state_d = ST_ENT_START;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
		end else begin
			state_q <= state_d;
			if (start && (req.command == CMD_SET_VALID) && ei_ok) begin
				valid_q[EW'(req.entry_index)] <= req.valid_value;
			end
		end
	end

	always_ff @(posedge clk) begin
		ent_q    <= ent_d;
		pos_q    <= pos_d;
		zero_q   <= zero_d;
		len_q    <= len_d;
		k_q      <= k_d;
		rx_cnt_q <= rx_cnt_d;
		dcnt_q   <= dcnt_d;
		rcnt_q   <= rcnt_d;
		seen_q   <= seen_d;
	end

	assign busy = (state_q != ST_IDLE);

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> (state_q == ST_IDLE))
		else $error("transaction started while sequencer busy");

	a_hit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(res.done && res.found) |-> valid_q[ent_q])
		else $error("hit reported on an invalid entry");

	a_cmp_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENT_CMP) |-> ((dcnt_q != '0) && (rcnt_q <= rx_cnt_q)))
		else $error("compare pointers out of range");

	a_lookup_not_instant: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (req.command == CMD_LOOKUP)) |-> !res.done)
		else $error("lookup finished in its accept cycle");

	a_flag_rmw: assert property (@(posedge clk) disable iff (!arst_n)
		f_we |-> ($past(start) && ($past(req.command) == CMD_WR_REG)))
		else $error("flag write without a preceding character write");
endmodule
`default_nettype wire

### rtl/wildcard_suffix_number_lookup.sv
// Channel | Dir | Handshake   | Payload
// --------+-----+-------------+--------------------------------------------------
// req     | in  | valid/ready | command, entry_index, char_position, char_value,
//         |     |             | valid_value, received_length
// rsp     | out | valid/ready | found, match_index (one per req transaction)
//
// Timing: set-valid and write-received finish in the accept cycle, write-registered adds
//   a state for the zero-mask read-modify-write. A lookup counts the leading digits, then
//   steps through the entries, skipping invalid ones and comparing valid ones from the tail
//   at one entry character compared per cycle; rsp shows the result in the cycle after.
// Reset: arst_n clears sequencer, valid flags and output register; characters undefined.
// Stalls: req waits while busy or while a held rsp is not draining; nothing lost or repeated.
`default_nettype none
module wildcard_suffix_number_lookup #(
	parameter int unsigned ENTRIES  = wsnl_pkg::ENTRIES_DEF,
	parameter int unsigned DIAL_LEN = wsnl_pkg::DIAL_LEN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	wsnl_stream_if.sink   req,
	wsnl_stream_if.source rsp
);
	import wsnl_pkg::*;

	logic     start;
	logic     busy;
	seq_res_t res;
	logic     rsp_valid_q;
	rsp_t     rsp_data_q;

	// Output slot is free or being emptied: a result that completes in the
	// accept cycle (non-lookup commands) can always be stored. A lookup leaves
	// the slot empty until its own result.
	assign req.ready = !busy && (!rsp_valid_q || rsp.ready);
	assign start     = req.valid && req.ready;

	wsnl_seq #(.ENTRIES(ENTRIES), .DIAL_LEN(DIAL_LEN)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req.payload),
		.busy   (busy),
		.res    (res)
	);

	// result register: parts the sequencer from the rsp consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res.done) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.done) begin
			rsp_data_q.found       <= res.found;
			rsp_data_q.match_index <= res.match_index;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;
endmodule
`default_nettype wire

### dv/wsnl_lookup_checker.sv
module wsnl_lookup_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  wsnl_pkg::req_t   req_payload,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  wsnl_pkg::rsp_t   rsp_payload,
	output int unsigned      pending,
	output int unsigned      errors
);
	import wsnl_pkg::*;

	localparam int NUM_ENT = ENTRIES_DEF;
	localparam int NUM_POS = DIAL_LEN_DEF;

	logic [7:0] stored_num [NUM_ENT][NUM_POS];
	logic       entry_live [NUM_ENT];
	logic [7:0] caller_num [NUM_POS];
	rsp_t       answers_due [$];
	int unsigned mismatches = 0;

	assign errors = mismatches;

	function automatic logic dial_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic dial_kept(input logic [7:0] c);
		return dial_digit(c) || (c == CH_STAR);
	endfunction

	// entry e is a suffix of caller digits 0..last, compared from the tail
	function automatic logic suffix_hit(input int e, input int last);
		int stop_at;
		int dp;
		int rp;
		stop_at = NUM_POS - 1;
		for (int p = 1; p < NUM_POS; p++) begin
			if (stored_num[e][p] == CH_NUL) begin
				stop_at = p - 1;
				break;
			end
		end
		dp = stop_at;
		while (dp >= 0 && !dial_kept(stored_num[e][dp]))
			dp--;
		if (dp < 0)
			return 1'b0;
		rp = last;
		while (rp >= 0 && dp >= 0) begin
			while (dp >= 0 && !dial_kept(stored_num[e][dp]))
				dp--;
			if (dp < 0)
				break;
			if (stored_num[e][dp] != CH_STAR && caller_num[rp] != stored_num[e][dp])
				break;
			dp--;
			rp--;
		end
		return dp < 0;
	endfunction

	function automatic rsp_t caller_lookup(input logic [5:0] len);
		rsp_t res;
		int   n;
		int   last;
		res = '0;
		n = (len > NUM_POS) ? NUM_POS : int'(len);
		if (caller_num[0] == CH_NUL)
			return res;
		last = n - 1;
		for (int k = 0; k < n; k++) begin
			if (!dial_digit(caller_num[k])) begin
				last = k - 1;
				break;
			end
		end
		for (int e = 0; e < NUM_ENT; e++) begin
			if (entry_live[e] && suffix_hit(e, last)) begin
				res.found = 1'b1;
				res.match_index = 5'(e);
				break;
			end
		end
		return res;
	endfunction

	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		res = '0;
		case (r.command)
			CMD_WR_REG: begin
				if (r.entry_index < NUM_ENT && r.char_position < NUM_POS)
					stored_num[r.entry_index][r.char_position] = r.char_value;
			end
			CMD_SET_VALID: begin
				if (r.entry_index < NUM_ENT)
					entry_live[r.entry_index] = r.valid_value;
			end
			CMD_WR_RX: begin
				if (r.char_position < NUM_POS)
					caller_num[r.char_position] = r.char_value;
			end
			default: res = caller_lookup(r.received_length);
		endcase
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		rsp_t got;
		if (!arst_n) begin
			for (int e = 0; e < NUM_ENT; e++)
				entry_live[e] = 1'b0;
			answers_due.delete();
			pending = 0;
		end else begin
			// drain first: a result can never belong to a request taken at the same edge
			if (rsp_valid && rsp_ready) begin
				got = rsp_payload;
				if (answers_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result found=%0b match_index=%0d",
							$time, got.found, got.match_index);
				end else begin
					want = answers_due.pop_front();
					if (got.found !== want.found || got.match_index !== want.match_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: mismatch found exp=%0b got=%0b, match_index exp=%0d got=%0d",
								$time, want.found, got.found, want.match_index, got.match_index);
					end
				end
			end
			if (req_valid && req_ready)
				answers_due.push_back(apply_request(req_payload));
			pending = answers_due.size();
		end
	end

endmodule

### dv/tb_top.sv
// Stimulus and verdict for the wildcard suffix number lookup.
// The checker beside the DUT predicts every result; this module builds
// transactions, drives rsp back-pressure and keeps a shadow of what has been written, so that no
// lookup ever reads a character slot that was never written.
module tb_top;
	import wsnl_pkg::*;

	localparam int NUM_ENT        = ENTRIES_DEF;
	localparam int NUM_POS        = DIAL_LEN_DEF;
	localparam int ITEM_TARGET    = 540;
	// covers the worst lookup, plus both stalls
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int DRAIN_CYCLES   = 20;

	logic clk = 1'b0;
	logic arst_n;

	wsnl_stream_if #(.data_t(req_t)) req_if ();
	wsnl_stream_if #(.data_t(rsp_t)) rsp_if ();

	int unsigned pending;
	int unsigned errors;

	wildcard_suffix_number_lookup u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	wsnl_lookup_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_if.valid),
		.req_ready   (req_if.ready),
		.req_payload (req_if.payload),
		.rsp_valid   (rsp_if.valid),
		.rsp_ready   (rsp_if.ready),
		.rsp_payload (rsp_if.payload),
		.pending     (pending),
		.errors      (errors)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the DUT storage: which slots hold a defined character.
	logic [7:0] sh_chars  [NUM_ENT][NUM_POS];
	bit         sh_set    [NUM_ENT][NUM_POS];
	bit         sh_on     [NUM_ENT];
	logic [7:0] sh_rx     [NUM_POS];
	bit         sh_rx_set [NUM_POS];

	int unsigned sent_items = 0;
	bit          send_calm  = 1'b0;
	bit          take_calm  = 1'b0;
	int unsigned stall_cnt  = 0;

	function automatic bit is_dial_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	// non-zero, not a digit, not a star
	function automatic logic [7:0] junk_char();
		logic [7:0] v;
		v = 8'($urandom_range(1, 255));
		while (is_dial_digit(v) || v == CH_STAR)
			v = 8'($urandom_range(1, 255));
		return v;
	endfunction

	function automatic logic [7:0] rand_digit();
		return CH_ZERO + 8'($urandom_range(0, 9));
	endfunction

	// Terminator scan of a valid entry must only touch written slots.
	function automatic bit entry_safe(input int e);
		if (!sh_set[e][0])
			return 1'b0;
		for (int p = 1; p < NUM_POS; p++) begin
			if (!sh_set[e][p])
				return 1'b0;
			if (sh_chars[e][p] == CH_NUL)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// Largest received_length whose digit scan stays in written slots;
	// -1 when slot 0 itself is undefined.
	function automatic int rx_room();
		if (!sh_rx_set[0])
			return -1;
		if (sh_rx[0] == CH_NUL)
			return 63;
		for (int k = 0; k < NUM_POS; k++) begin
			if (!sh_rx_set[k])
				return k;
			if (!is_dial_digit(sh_rx[k]))
				return 63;
		end
		return 63;
	endfunction

	function automatic int leading_digits();
		int n;
		n = 0;
		while (n < NUM_POS && sh_rx_set[n] && is_dial_digit(sh_rx[n]))
			n++;
		return n;
	endfunction

	// all fields random, so that don't-care bits toggle too
	function automatic req_t random_req(input cmd_t c);
		req_t r;
		r.command         = c;
		r.entry_index     = 5'($urandom);
		r.char_position   = 5'($urandom);
		r.char_value      = 8'($urandom);
		r.valid_value     = 1'($urandom);
		r.received_length = 6'($urandom_range(0, 63));
		return r;
	endfunction

	// Drive at negedge, hold until taken at a posedge. valid stays up between
	// back-to-back transactions, so each negedge sees one assignment at most.
	task automatic push_req(input req_t r);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 14);
		@(negedge clk);
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do @(posedge clk); while (req_if.ready !== 1'b1);
		sent_items++;
	endtask

	// Keeps the shadow current and bends a transaction that would make a later
	// lookup read undefined storage.
	task automatic issue(input req_t r);
		logic [7:0] old_char;
		bit         old_set;
		int         room;
		req_t       fix;
		case (r.command)
			CMD_WR_REG: begin
				if (sh_on[r.entry_index]) begin
					old_char = sh_chars[r.entry_index][r.char_position];
					old_set  = sh_set[r.entry_index][r.char_position];
					sh_chars[r.entry_index][r.char_position] = r.char_value;
					sh_set[r.entry_index][r.char_position]   = 1'b1;
					// overwriting the terminator of a live entry: keep it a terminator
					if (!entry_safe(r.entry_index))
						r.char_value = CH_NUL;
					sh_chars[r.entry_index][r.char_position] = old_char;
					sh_set[r.entry_index][r.char_position]   = old_set;
				end
				sh_chars[r.entry_index][r.char_position] = r.char_value;
				sh_set[r.entry_index][r.char_position]   = 1'b1;
			end
			CMD_SET_VALID: begin
				if (r.valid_value && !entry_safe(r.entry_index))
					r.valid_value = 1'b0;
				sh_on[r.entry_index] = r.valid_value;
			end
			CMD_WR_RX: begin
				sh_rx[r.char_position]     = r.char_value;
				sh_rx_set[r.char_position] = 1'b1;
			end
			default: begin
				room = rx_room();
				if (room < 0) begin
					fix = random_req(CMD_WR_RX);
					fix.char_position = '0;
					fix.char_value    = rand_digit();
					sh_rx[0]     = fix.char_value;
					sh_rx_set[0] = 1'b1;
					push_req(fix);
					room = rx_room();
				end
				if (int'(r.received_length) > room)
					r.received_length = 6'(room);
			end
		endcase
		push_req(r);
	endtask

	task automatic reg_char(input int e, input int p, input logic [7:0] v);
		req_t r;
		r = random_req(CMD_WR_REG);
		r.entry_index   = 5'(e);
		r.char_position = 5'(p);
		r.char_value    = v;
		issue(r);
	endtask

	task automatic rx_char(input int p, input logic [7:0] v);
		req_t r;
		r = random_req(CMD_WR_RX);
		r.char_position = 5'(p);
		r.char_value    = v;
		issue(r);
	endtask

	task automatic mark(input int e, input bit on);
		req_t r;
		r = random_req(CMD_SET_VALID);
		r.entry_index = 5'(e);
		r.valid_value = on;
		issue(r);
	endtask

	task automatic lookup(input int len);
		req_t r;
		r = random_req(CMD_LOOKUP);
		r.received_length = 6'(len);
		issue(r);
	endtask

	// Terminator first, then characters from the tail down, so a live entry
	// never passes through a state with an undefined slot in reach.
	task automatic write_entry(input int e, input logic [7:0] chars [$]);
		if (chars.size() < NUM_POS)
			reg_char(e, chars.size(), CH_NUL);
		for (int i = chars.size() - 1; i >= 0; i--)
			reg_char(e, i, chars[i]);
	endtask

	// One incoming call: maybe a new caller number, a few entries built from
	// its tail (stars, junk, some wrong digits), then lookups at several lengths.
	task automatic call_scenario();
		logic [7:0] pat [$];
		int n;
		int cur;
		int s;
		int e;
		int len;
		if ($urandom_range(0, 2) == 0 && leading_digits() > 0) begin
			cur = leading_digits();
		end else begin
			n = ($urandom_range(0, 9) == 0) ? NUM_POS : $urandom_range(1, 14);
			for (int i = 0; i < n; i++)
				rx_char(i, rand_digit());
			if (n < NUM_POS) begin
				case ($urandom_range(0, 2))
					0: rx_char(n, CH_NUL);
					1: rx_char(n, junk_char());
					default: ;
				endcase
			end
			cur = leading_digits();
		end

		// thin out old live entries now and then so later indexes can win
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 4)) mark($urandom_range(0, NUM_ENT - 1), 1'b0);

		repeat ($urandom_range(1, 3)) begin
			pat.delete();
			e = $urandom_range(0, NUM_ENT - 1);
			s = $urandom_range(1, (cur < 6) ? cur : 6);
			for (int i = cur - s; i < cur; i++) begin
				if ($urandom_range(0, 6) == 0)
					pat.push_back(junk_char());
				case ($urandom_range(0, 9))
					0, 1: pat.push_back(CH_STAR);
					2: pat.push_back(rand_digit());
					default: pat.push_back(sh_rx[i]);
				endcase
			end
			if ($urandom_range(0, 4) == 0)
				pat.push_back(junk_char());
			// entry with no terminator: runs to the last slot
			if ($urandom_range(0, 9) == 0)
				while (pat.size() < NUM_POS)
					pat.push_front(junk_char());
			write_entry(e, pat);
			mark(e, $urandom_range(0, 4) != 0);
		end

		repeat ($urandom_range(1, 3)) begin
			case ($urandom_range(0, 3))
				0: len = cur;
				1: len = 63;
				2: len = $urandom_range(0, 63);
				default: len = (cur > 1) ? $urandom_range(1, cur - 1) : cur;
			endcase
			lookup(len);
		end
	endtask

	// Result side: random back-pressure, with calm stretches.
	initial begin
		int gap;
		forever begin
			if ($urandom_range(0, 39) == 0)
				take_calm = !take_calm;
			gap = take_calm ? 0 : $urandom_range(0, 14);
			@(negedge clk);
			if (gap > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (rsp_if.valid !== 1'b1);
		end
	end

	// Watchdog: cycles without any transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt + 1 >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		rsp_if.ready   = 1'b0;
		arst_n         = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// empty caller number, length above the buffer size
		rx_char(0, CH_NUL);
		lookup(63);
		// entry 31 = "5"; entry 0 has no digit at all
		reg_char(31, 0, "5");
		reg_char(31, 1, CH_NUL);
		mark(31, 1'b1);
		reg_char(0, 0, "-");
		reg_char(0, 1, CH_NUL);
		mark(0, 1'b1);
		// entry 5: zero in slot 0 is not an end mark, then "5"
		reg_char(5, 0, CH_NUL);
		reg_char(5, 1, "5");
		reg_char(5, 2, CH_NUL);
		mark(5, 1'b1);
		// caller "12345", stopped by an all-ones byte; last slot written too
		rx_char(0, "1");
		rx_char(1, "2");
		rx_char(2, "3");
		rx_char(3, "4");
		rx_char(4, "5");
		rx_char(5, 8'hFF);
		rx_char(NUM_POS - 1, 8'hFF);
		lookup(32);
		mark(5, 1'b0);
		lookup(6);
		lookup(4);
		// caller that does not start with a digit
		rx_char(0, "A");
		lookup(63);
		mark(0, 1'b0);

		// hold off until the directed part has fully drained
		@(negedge clk);
		req_if.valid <= 1'b0;
		wait (pending == 0);

		while (sent_items < ITEM_TARGET) begin
			if ($urandom_range(0, 4) < 3)
				call_scenario();
			else
				issue(random_req(cmd_t'($urandom_range(0, 3))));
			if ($urandom_range(0, 39) == 0) begin
				@(negedge clk);
				req_if.valid <= 1'b0;
				wait (pending == 0);
			end
		end

		@(negedge clk);
		req_if.valid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
rtl/wsnl_pkg.sv
rtl/wsnl_stream_if.sv
rtl/wsnl_ram.sv
rtl/wsnl_seq.sv
rtl/wildcard_suffix_number_lookup.sv
dv/wsnl_lookup_checker.sv
dv/tb_top.sv
